// ===== hw/rtl/dss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual stack package
// Shared constants, operation and status codes, and the result type passed
// from the stack controller to the top level.
// ----------------------------------------------------------------------------
package dss_pkg;

   localparam int CAP_W          = 11;
   localparam int OPCODE_W       = 2;
   localparam int STATUS_W       = 2;
   localparam int WORD_W         = 32;
   localparam int DEPTH_DEF      = 1024;
   localparam int DATA_WIDTH_DEF = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PEEK  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                empty_flag;
      logic                use_read;
   } dss_result_type;

endpackage
`default_nettype wire

// ===== hw/rtl/dss_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/dss_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual stack controller
// Holds the capacity register and both stack counts, decides the outcome of
// each transaction and issues the memory access for it.
// ----------------------------------------------------------------------------
module dss_ctrl #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [dss_pkg::CAP_W-1:0]      csr_data,
   input  wire logic                           item_accept,
   input  wire logic [dss_pkg::OPCODE_W-1:0]   opcode,
   input  wire logic                           stack_select,
   input  wire logic signed [dss_pkg::WORD_W-1:0] push_value,
   output logic                                mem_wr_en,
   output logic                                mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]            mem_addr,
   output logic [DATA_WIDTH-1:0]               mem_wr_data,
   output dss_pkg::dss_result_type             result
);
   import dss_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] low_count_ff, low_count_in;
   logic [CNT_W-1:0] high_count_ff, high_count_in;

   logic [CMP_W-1:0] capacity_ext;
   logic [CNT_W-1:0] cap;
   logic [CNT_W:0]   total;
   logic             full;
   logic [CNT_W-1:0] sel_count;
   logic [CNT_W-1:0] new_count;
   logic [CNT_W-1:0] push_addr;
   logic [CNT_W-1:0] top_addr;
   logic             is_empty;

   always_comb begin
      capacity_ext = CMP_W'(capacity_ff);
      if (capacity_ext > CMP_W'(DEPTH)) begin
         cap = CNT_W'(DEPTH);
      end else begin
         cap = capacity_ext[CNT_W-1:0];
      end
      total     = {1'b0, low_count_ff} + {1'b0, high_count_ff};
      full      = total >= {1'b0, cap};
      sel_count = stack_select ? high_count_ff : low_count_ff;
      is_empty  = sel_count == '0;
      push_addr = stack_select ? (cap - CNT_W'(1) - high_count_ff) : low_count_ff;
      top_addr  = stack_select ? (cap - high_count_ff) : (low_count_ff - CNT_W'(1));

      new_count       = sel_count;
      mem_wr_en       = 1'b0;
      mem_rd_en       = 1'b0;
      mem_addr        = top_addr[ADDR_W-1:0];
      result.status   = ST_OK;
      result.use_read = 1'b0;
      case (opcode)
         OP_PUSH: begin
            mem_addr = push_addr[ADDR_W-1:0];
            if (full) begin
               result.status = ST_FULL;
            end else begin
               mem_wr_en = item_accept;
               new_count = sel_count + CNT_W'(1);
            end
         end
         OP_POP, OP_PEEK: begin
            if (is_empty) begin
               result.status = ST_EMPTY;
            end else begin
               mem_rd_en       = item_accept;
               result.use_read = 1'b1;
               if (opcode == OP_POP) begin
                  new_count = sel_count - CNT_W'(1);
               end
            end
         end
         default: begin
            new_count = sel_count;
         end
      endcase
      result.empty_flag = new_count == '0;
      mem_wr_data = DATA_WIDTH'($unsigned(push_value));

      capacity_in   = capacity_ff;
      low_count_in  = low_count_ff;
      high_count_in = high_count_ff;
      if (csr_write) begin
         capacity_in   = csr_data;
         low_count_in  = '0;
         high_count_in = '0;
      end else if (item_accept) begin
         if (stack_select) begin
            high_count_in = new_count;
         end else begin
            low_count_in = new_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAP_RESET;
         low_count_ff  <= '0;
         high_count_ff <= '0;
      end else begin
         capacity_ff   <= capacity_in;
         low_count_ff  <= low_count_in;
         high_count_ff <= high_count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/dual_stack_shared_memory.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual stack shared memory
// Two LIFO stacks in one memory, the low stack growing up from entry zero and
// the high stack growing down from the top of the configured capacity.
// ----------------------------------------------------------------------------
// A request is registered into the read stage along with its memory read, then
// into the response register, which holds the response until rsp_ready takes it.
// Throughput: one transaction per cycle, set by the single memory access each
// transaction makes; the memory read stage stalls only while the response is held.
// Reset: both counts return to zero and capacity to 1024; memory contents are
// not cleared and no clearing pass runs. A capacity write also empties both stacks.
module dual_stack_shared_memory #(
   parameter int DEPTH      = dss_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = dss_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dss_pkg::CAP_W-1:0]         csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [dss_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire logic                              req_stack_select,
   input  wire logic signed [dss_pkg::WORD_W-1:0] req_push_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [dss_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [dss_pkg::WORD_W-1:0]      rsp_data_out,
   output logic                                   rsp_empty_flag
);
   import dss_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic                  item_accept;
   logic                  mem_wr_en;
   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic [DATA_WIDTH-1:0] mem_rd_data;
   dss_result_type        result;

   logic                  s1_valid_ff, s1_valid_in;
   dss_result_type        s1_result_ff, s1_result_in;
   logic                  s1_move;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   assign csr_ready   = 1'b1;
   assign s1_move     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_move;
   assign item_accept = req_valid && req_ready;

   dss_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .item_accept  (item_accept),
      .opcode       (req_opcode),
      .stack_select (req_stack_select),
      .push_value   (req_push_value),
      .mem_wr_en    (mem_wr_en),
      .mem_rd_en    (mem_rd_en),
      .mem_addr     (mem_addr),
      .mem_wr_data  (mem_wr_data),
      .result       (result)
   );

   dss_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_result_in = s1_result_ff;
      if (item_accept) begin
         s1_valid_in  = 1'b1;
         s1_result_in = result;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (s1_move) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = s1_result_ff.status;
         rsp_empty_in  = s1_result_ff.empty_flag;
         rsp_data_in   = s1_result_ff.use_read ? WORD_W'(mem_rd_data) : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_result_ff  <= s1_result_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_empty_flag = rsp_empty_ff;

endmodule
`default_nettype wire
